// ----- hw/rtl/dcs_pkg.sv -----
// dcs_pkg: shared types and constants for the digit crop, scale and centre block
// register indexes, register file struct and the queue word between front and back
// no dependencies
package dcs_pkg;

   localparam int MAX_SIDE_DEF   = 512;
   localparam int OUT_WIDTH_DEF  = 28;
   localparam int OUT_HEIGHT_DEF = 28;
   localparam int FIT_SIDE_DEF   = 20;

   localparam int DIM_W       = 10;
   localparam int BOX_W       = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COLS = 3'd0,
      CSR_FRAME_ROWS = 3'd1,
      CSR_BOX_LEFT   = 3'd2,
      CSR_BOX_RIGHT  = 3'd3,
      CSR_BOX_TOP    = 3'd4,
      CSR_BOX_BOTTOM = 3'd5,
      CSR_BOX_VALID  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] frame_cols;
      logic [DIM_W-1:0] frame_rows;
      logic [BOX_W-1:0] box_left;
      logic [BOX_W-1:0] box_right;
      logic [BOX_W-1:0] box_top;
      logic [BOX_W-1:0] box_bottom;
      logic             box_valid;
   } cfg_type;

   // one queue word: an ink pixel to map, an end of frame, or both
   typedef struct packed {
      logic             mark;
      logic             eof;
      logic             ok;
      logic [BOX_W-1:0] col_ofs;
      logic [BOX_W-1:0] row_ofs;
   } entry_type;

endpackage

// ----- hw/rtl/dcs_divider.sv -----
// dcs_divider: restoring divider, one quotient bit per cycle
// quotient must fit in QW bits; no package dependency
module dcs_divider #(
   parameter int NW = 17,
   parameter int DW = 10,
   parameter int QW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [QW-1:0] quot
);
   localparam int KW = (QW > 1) ? $clog2(QW) : 1;
   localparam int TW = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [KW-1:0] k_ff, k_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [TW-1:0] trial;
   logic [TW-1:0] rem_x;

   always_comb begin
      trial   = TW'(den_ff) << k_ff;
      rem_x   = TW'(rem_ff);
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         den_in  = denom;
         quot_in = '0;
         k_in    = KW'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_x >= trial) begin
            rem_in        = NW'(rem_x - trial);
            quot_in[k_ff] = 1'b1;
         end
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      k_ff    <= k_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- hw/rtl/dcs_front.sv -----
// dcs_front: register file, raster counters and pixel classification
// uses dcs_pkg; pushes ink pixels inside the box and frame ends to the queue
module dcs_front #(
   parameter int MAX_SIDE = dcs_pkg::MAX_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_pixel_on,
   input  logic                            req_end_of_frame,
   output dcs_pkg::cfg_type                cfg,
   output logic                            push_valid,
   output dcs_pkg::entry_type              push_entry,
   input  logic                            push_ready
);
   import dcs_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int XW = ((CW > DIM_W) ? CW : DIM_W) + 1;

   cfg_type       cfg_ff, cfg_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [XW-1:0] col_x, row_x;
   logic          box_ok, in_box, accept, wrap;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_COLS: cfg_in.frame_cols = csr_wdata[DIM_W-1:0];
            CSR_FRAME_ROWS: cfg_in.frame_rows = csr_wdata[DIM_W-1:0];
            CSR_BOX_LEFT:   cfg_in.box_left   = csr_wdata[BOX_W-1:0];
            CSR_BOX_RIGHT:  cfg_in.box_right  = csr_wdata[BOX_W-1:0];
            CSR_BOX_TOP:    cfg_in.box_top    = csr_wdata[BOX_W-1:0];
            CSR_BOX_BOTTOM: cfg_in.box_bottom = csr_wdata[BOX_W-1:0];
            CSR_BOX_VALID:  cfg_in.box_valid  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      col_x  = XW'(col_ff);
      row_x  = XW'(row_ff);
      box_ok = cfg_ff.box_valid
               && (cfg_ff.box_left <= cfg_ff.box_right)
               && (cfg_ff.box_top <= cfg_ff.box_bottom)
               && (XW'(cfg_ff.box_right) < XW'(cfg_ff.frame_cols))
               && (XW'(cfg_ff.box_bottom) < XW'(cfg_ff.frame_rows));
      in_box = box_ok && req_pixel_on
               && (col_x >= XW'(cfg_ff.box_left)) && (col_x <= XW'(cfg_ff.box_right))
               && (row_x >= XW'(cfg_ff.box_top)) && (row_x <= XW'(cfg_ff.box_bottom));

      req_ready  = push_ready;
      accept     = req_valid && push_ready;
      push_valid = accept && (in_box || req_end_of_frame);

      push_entry.mark    = in_box;
      push_entry.eof     = req_end_of_frame;
      push_entry.ok      = box_ok;
      push_entry.col_ofs = BOX_W'(col_x - XW'(cfg_ff.box_left));
      push_entry.row_ofs = BOX_W'(row_x - XW'(cfg_ff.box_top));

      // width zero behaves like width one, and the counter never passes the side limit
      wrap   = ((col_x + 1'b1) >= XW'(cfg_ff.frame_cols)) || (col_ff >= CW'(MAX_SIDE - 1));
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (req_end_of_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = (row_ff == CW'(MAX_SIDE - 1)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_cols <= DIM_RESET;
         cfg_ff.frame_rows <= DIM_RESET;
         cfg_ff.box_left   <= '0;
         cfg_ff.box_right  <= '0;
         cfg_ff.box_top    <= '0;
         cfg_ff.box_bottom <= '0;
         cfg_ff.box_valid  <= 1'b0;
         col_ff            <= '0;
         row_ff            <= '0;
      end else begin
         cfg_ff <= cfg_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/dcs_queue.sv -----
// dcs_queue: short word queue between the front and the back
// uses dcs_pkg for the queue word type
module dcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  dcs_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output dcs_pkg::entry_type pop_entry,
   input  logic               pop_ready
);
   import dcs_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   entry_type     mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != (AW+1)'(QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_entry  = mem_ff[rd_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_in      = wr_ff;
      rd_in      = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/dcs_back.sv -----
// dcs_back: geometry, forward mapping into the image rows and row word output
// uses dcs_pkg and dcs_divider; one shared divider does every division
module dcs_back #(
   parameter int OUT_WIDTH  = dcs_pkg::OUT_WIDTH_DEF,
   parameter int OUT_HEIGHT = dcs_pkg::OUT_HEIGHT_DEF,
   parameter int FIT_SIDE   = dcs_pkg::FIT_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  dcs_pkg::cfg_type              cfg,
   input  logic                          pop_valid,
   input  dcs_pkg::entry_type            pop_entry,
   output logic                          pop_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OUT_WIDTH-1:0]          rsp_row_bits,
   output logic [$clog2(OUT_HEIGHT)-1:0] rsp_row_number,
   output logic                          rsp_ok,
   output logic                          rsp_last_row
);
   import dcs_pkg::*;

   localparam int MAXO = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
   localparam int MAXQ = (MAXO > FIT_SIDE) ? MAXO : FIT_SIDE;
   localparam int QW   = $clog2(MAXQ + 1);
   localparam int FW   = $clog2(FIT_SIDE + 1);
   localparam int NWG  = DIM_W + FW + 1;
   localparam int NWM  = BOX_W + QW;
   localparam int NW   = (NWG > NWM) ? NWG : NWM;
   localparam int RW   = $clog2(OUT_HEIGHT);
   localparam int PW   = QW + 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_GEO_C = 6'b000010,
      ST_GEO_R = 6'b000100,
      ST_MAP_X = 6'b001000,
      ST_MAP_Y = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SEL_GEO_C = 2'd0,
      SEL_GEO_R = 2'd1,
      SEL_MAP_X = 2'd2,
      SEL_MAP_Y = 2'd3
   } div_sel_type;

   state_type              state_ff, state_in;
   entry_type              ent_ff, ent_in;
   logic                   dirty_ff, dirty_in;
   logic [QW-1:0]          sc_ff, sc_in, sr_ff, sr_in, qx_ff, qx_in;
   logic [RW-1:0]          k_ff, k_in;
   logic [OUT_WIDTH-1:0]   rows_ff [OUT_HEIGHT];
   logic [OUT_WIDTH-1:0]   rows_in [OUT_HEIGHT];
   logic [DIM_W-1:0]       sw, sh, mx;
   logic [QW-1:0]          col_off, row_off;
   logic [PW-1:0]          dx, dy;
   logic [BOX_W-1:0]       mark_col;
   div_sel_type            div_sel;
   logic                   div_start, div_done, set_bit;
   logic [NW-1:0]          div_num;
   logic [DIM_W-1:0]       div_den;
   logic [QW-1:0]          div_q;

   function automatic logic [QW-1:0] clamp_side(input logic [QW-1:0] q, input int limit);
      logic [QW-1:0] s;
      s = q;
      if (s == '0) s = QW'(1);
      if (s > QW'(limit)) s = QW'(limit);
      return s;
   endfunction

   dcs_divider #(.NW(NW), .DW(DIM_W), .QW(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      sw       = DIM_W'(cfg.box_right) - DIM_W'(cfg.box_left) + 1'b1;
      sh       = DIM_W'(cfg.box_bottom) - DIM_W'(cfg.box_top) + 1'b1;
      mx       = (sw > sh) ? sw : sh;
      col_off  = QW'((QW'(OUT_WIDTH) - sc_ff) >> 1);
      row_off  = QW'((QW'(OUT_HEIGHT) - sr_ff) >> 1);
      // in idle the mark has not been latched yet
      mark_col = (state_ff == ST_IDLE) ? pop_entry.col_ofs : ent_ff.col_ofs;
      unique case (div_sel)
         SEL_GEO_C: begin
            div_num = NW'(sw) * NW'(FIT_SIDE) + NW'(mx >> 1);
            div_den = mx;
         end
         SEL_GEO_R: begin
            div_num = NW'(sh) * NW'(FIT_SIDE) + NW'(mx >> 1);
            div_den = mx;
         end
         SEL_MAP_X: begin
            div_num = NW'(mark_col) * NW'(sc_ff);
            div_den = sw;
         end
         SEL_MAP_Y: begin
            div_num = NW'(ent_ff.row_ofs) * NW'(sr_ff);
            div_den = sh;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      ent_in    = ent_ff;
      dirty_in  = dirty_ff | csr_we;
      sc_in     = sc_ff;
      sr_in     = sr_ff;
      qx_in     = qx_ff;
      k_in      = k_ff;
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      div_sel   = SEL_GEO_C;
      set_bit   = 1'b0;
      dx        = PW'(col_off) + PW'(qx_ff);
      dy        = PW'(row_off) + PW'(div_q);
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               ent_in    = pop_entry;
               k_in      = '0;
               if (pop_entry.mark) begin
                  div_start = 1'b1;
                  if (dirty_ff) begin
                     div_sel  = SEL_GEO_C;
                     state_in = ST_GEO_C;
                  end else begin
                     div_sel  = SEL_MAP_X;
                     state_in = ST_MAP_X;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_GEO_C: begin
            if (div_done) begin
               sc_in     = clamp_side(div_q, OUT_WIDTH);
               div_start = 1'b1;
               div_sel   = SEL_GEO_R;
               state_in  = ST_GEO_R;
            end
         end
         ST_GEO_R: begin
            if (div_done) begin
               sr_in     = clamp_side(div_q, OUT_HEIGHT);
               dirty_in  = csr_we;
               div_start = 1'b1;
               div_sel   = SEL_MAP_X;
               state_in  = ST_MAP_X;
            end
         end
         ST_MAP_X: begin
            if (div_done) begin
               qx_in     = div_q;
               div_start = 1'b1;
               div_sel   = SEL_MAP_Y;
               state_in  = ST_MAP_Y;
            end
         end
         ST_MAP_Y: begin
            if (div_done) begin
               set_bit  = (dx < PW'(OUT_WIDTH)) && (dy < PW'(OUT_HEIGHT));
               state_in = ent_ff.eof ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (k_ff == RW'(OUT_HEIGHT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // rows are cleared as they are sent, so the store is empty for the next frame
   always_comb begin
      for (int r = 0; r < OUT_HEIGHT; r++) begin
         rows_in[r] = rows_ff[r];
         for (int c = 0; c < OUT_WIDTH; c++) begin
            if (set_bit && (dy == PW'(r)) && (dx == PW'(c))) begin
               rows_in[r][c] = 1'b1;
            end
         end
         if (rsp_valid && rsp_ready && (k_ff == RW'(r))) begin
            rows_in[r] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b1;
         sc_ff    <= '0;
         sr_ff    <= '0;
         k_ff     <= '0;
         for (int r = 0; r < OUT_HEIGHT; r++) begin
            rows_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         sc_ff    <= sc_in;
         sr_ff    <= sr_in;
         k_ff     <= k_in;
         for (int r = 0; r < OUT_HEIGHT; r++) begin
            rows_ff[r] <= rows_in[r];
         end
      end
      ent_ff <= ent_in;
      qx_ff  <= qx_in;
   end

   assign rsp_row_bits   = ent_ff.ok ? rows_ff[k_ff] : '0;
   assign rsp_row_number = k_ff;
   assign rsp_ok         = ent_ff.ok;
   assign rsp_last_row   = (k_ff == RW'(OUT_HEIGHT - 1));

endmodule

// ----- hw/rtl/digit_crop_scale_center.sv -----
// digit_crop_scale_center: one-bit drawing to a centred fixed-size image, top level
// uses dcs_pkg, dcs_front, dcs_queue and dcs_back
//
//   port group  direction  handshake          carries
//   req_        in         req_valid/ready    pixel_on, end_of_frame
//   rsp_        out        rsp_valid/ready    row_bits, row_number, ok, last_row
//   csr_        in         csr_we             csr_index, csr_wdata
//
// a pixel outside the box or without ink is not queued; the queue absorbs bursts
// an ink pixel in the box runs a column and a row division on the shared divider of QW
// quotient bits, preceded after any register write by the column and row geometry
// divisions (geometry refresh)
// end of frame sends OUT_HEIGHT row words, one per cycle while rsp_ready is high
// reset clears counters, rows and registers at once; no clearing pass
module digit_crop_scale_center #(
   parameter int MAX_SIDE   = dcs_pkg::MAX_SIDE_DEF,
   parameter int OUT_WIDTH  = dcs_pkg::OUT_WIDTH_DEF,
   parameter int OUT_HEIGHT = dcs_pkg::OUT_HEIGHT_DEF,
   parameter int FIT_SIDE   = dcs_pkg::FIT_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_pixel_on,
   input  logic                            req_end_of_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [OUT_WIDTH-1:0]            rsp_row_bits,
   output logic [$clog2(OUT_HEIGHT)-1:0]   rsp_row_number,
   output logic                            rsp_ok,
   output logic                            rsp_last_row
);
   import dcs_pkg::*;

   cfg_type   cfg;
   entry_type push_entry, pop_entry;
   logic      push_valid, push_ready, pop_valid, pop_ready;

   dcs_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_on     (req_pixel_on),
      .req_end_of_frame (req_end_of_frame),
      .cfg              (cfg),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .push_ready       (push_ready)
   );

   dcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   dcs_back #(
      .OUT_WIDTH  (OUT_WIDTH),
      .OUT_HEIGHT (OUT_HEIGHT),
      .FIT_SIDE   (FIT_SIDE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .cfg            (cfg),
      .pop_valid      (pop_valid),
      .pop_entry      (pop_entry),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_row_number (rsp_row_number),
      .rsp_ok         (rsp_ok),
      .rsp_last_row   (rsp_last_row)
   );

endmodule
